// ----- rtl/tss_pkg.sv -----
`default_nettype none

package tss_pkg;

  // Default sizes
  localparam int unsigned NEIGHBOUR_ENTRIES_DEF = 16;
  localparam int unsigned SLOT_BITS_DEF         = 16;

  // Fixed field widths
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned OFFS_W     = 16;
  localparam int unsigned RETRY_W    = 8;
  localparam int unsigned RAND_W     = 16;
  localparam int unsigned NCNT_W     = 5;
  localparam int unsigned EIDX_W     = 4;
  localparam int unsigned MAC_W      = 3;

  // Decision constants
  localparam int unsigned RETRY_LIMIT  = 3;
  localparam int unsigned COLLECT_LEAD = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPLOAD_LEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_RX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GPS_WAKE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_SAVE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IS_ROOT      = 3'd6;

  // Register reset values
  localparam logic [CFG_W-1:0] WINDOW_LEN_RST  = 16'd600;
  localparam logic [CFG_W-1:0] UPLOAD_LEN_RST  = 16'd60;
  localparam logic [CFG_W-1:0] GLOBAL_RX_RST   = 16'd10;
  localparam logic [CFG_W-1:0] GPS_WAKE_RST    = 16'd3600;
  localparam logic [CFG_W-1:0] FLASH_SAVE_RST  = 16'd600;
  localparam logic [CFG_W-1:0] SYNC_GAIN_RST   = 16'd10;

  typedef enum logic [MAC_W-1:0] {
    MAC_DOZE   = 3'd0,
    MAC_RECV   = 3'd1,
    MAC_RTS    = 3'd2,
    MAC_NETOP  = 3'd3,
    MAC_HOP    = 3'd4,
    MAC_SYNC   = 3'd5
  } tss_mac_e;

  // Remainder operations run by the shared unit, in this order
  typedef enum logic [1:0] {
    OP_GPS    = 2'd0,
    OP_FLASH  = 2'd1,
    OP_WINDOW = 2'd2,
    OP_RXP    = 2'd3
  } tss_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CALC,
    ST_RD,
    ST_CMP,
    ST_FINISH
  } tss_state_e;

endpackage

`default_nettype wire

// ----- rtl/tdma_slot_scheduler.sv -----
`default_nettype none

// A table write gives its (all zero) result in the cycle after the transfer.
// A tick runs the four remainder operations, then walks the neighbour table (at most
// NEIGHBOUR_ENTRIES entries, stopping at a match) unless the slot is in the upload period.
// Table writes are taken one per cycle while idle; a new tick is not taken before the last one finishes.
// Reset: asynchronous, active low; registers, upload and sync state return to their
// defaults, the neighbour table is not cleared. The receiver cannot stall results.
module tdma_slot_scheduler #(
  parameter int unsigned NEIGHBOUR_ENTRIES = tss_pkg::NEIGHBOUR_ENTRIES_DEF,
  parameter int unsigned SLOT_BITS         = tss_pkg::SLOT_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command handshake
  input  wire logic                          start_i,
  output logic                               busy_o,
  output logic                               done_o,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [tss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [tss_pkg::CFG_W-1:0]     cfg_data_i,
  // item fields
  input  wire logic                          func_i,
  input  wire logic [SLOT_BITS-1:0]          slot_count_i,
  input  wire logic [SLOT_BITS-1:0]          tx_slot_i,
  input  wire logic                          net_op_pending_i,
  input  wire logic                          hop_pending_i,
  input  wire logic [tss_pkg::RETRY_W-1:0]   retries_i,
  input  wire logic                          has_gateway_route_i,
  input  wire logic [tss_pkg::RAND_W-1:0]    random_value_i,
  input  wire logic [tss_pkg::NCNT_W-1:0]    neighbour_count_i,
  input  wire logic [tss_pkg::EIDX_W-1:0]    entry_index_i,
  input  wire logic [SLOT_BITS-1:0]          entry_slot_i,
  // result fields
  output logic [tss_pkg::MAC_W-1:0]          mac_state_o,
  output logic                               run_mac_o,
  output logic                               start_upload_o,
  output logic                               gps_wake_o,
  output logic                               save_flash_o,
  output logic                               collect_data_o,
  output logic                               clear_net_op_o,
  output logic                               clear_retries_o,
  output logic                               request_route_o,
  output logic                               neighbour_heard_o
);
  import tss_pkg::*;

  localparam int unsigned IDX_W  = (NEIGHBOUR_ENTRIES > 1) ? $clog2(NEIGHBOUR_ENTRIES) : 1;
  localparam int unsigned KCNT_W = $clog2(NEIGHBOUR_ENTRIES + 1);
  localparam int unsigned BIT_W  = $clog2(SLOT_BITS);
  localparam int unsigned CMP_W  = (SLOT_BITS > OFFS_W) ? SLOT_BITS : OFFS_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] window_len_q, upload_len_q, global_rx_q;
  logic [CFG_W-1:0] gps_wake_q, flash_save_q, sync_gain_q;
  logic             is_root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= WINDOW_LEN_RST;
      upload_len_q <= UPLOAD_LEN_RST;
      global_rx_q  <= GLOBAL_RX_RST;
      gps_wake_q   <= GPS_WAKE_RST;
      flash_save_q <= FLASH_SAVE_RST;
      sync_gain_q  <= SYNC_GAIN_RST;
      is_root_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_LEN: window_len_q <= cfg_data_i;
        REG_UPLOAD_LEN: upload_len_q <= cfg_data_i;
        REG_GLOBAL_RX:  global_rx_q  <= cfg_data_i;
        REG_GPS_WAKE:   gps_wake_q   <= cfg_data_i;
        REG_FLASH_SAVE: flash_save_q <= cfg_data_i;
        REG_SYNC_GAIN:  sync_gain_q  <= cfg_data_i;
        REG_IS_ROOT:    is_root_q    <= cfg_data_i[0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  tss_state_e state_q, state_d;
  tss_op_e    op_q;
  logic [BIT_W-1:0] bit_q;
  logic [KCNT_W-1:0] k_q, cnt_q;
  logic       accept_w;
  logic       in_upload_w;
  logic       match_w;
  logic       k_last_w;
  logic [OFFS_W-1:0] offset_q;
  logic [OFFS_W-1:0] rd_q;

  assign accept_w    = start_i && (state_q == ST_IDLE);
  assign in_upload_w = (offset_q <= upload_len_q);
  assign match_w     = (rd_q == offset_q);
  assign k_last_w    = (KCNT_W'(k_q + 1'b1) == cnt_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept_w && !func_i) state_d = ST_MOD;
      ST_MOD:    if (bit_q == '0 && op_q == OP_RXP) state_d = ST_CALC;
      ST_CALC:   state_d = (in_upload_w || cnt_q == '0) ? ST_FINISH : ST_RD;
      ST_RD:     state_d = ST_CMP;
      ST_CMP:    state_d = (match_w || k_last_w) ? ST_FINISH : ST_RD;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  // ---------------------------------------------------------------------------
  // Item capture
  // ---------------------------------------------------------------------------
  logic [SLOT_BITS-1:0] slot_q, txs_q;
  logic                 nop_q, hop_q, route_q;
  logic [RETRY_W-1:0]   retries_q;
  logic [RAND_W-1:0]    thr_q;
  logic [2*RAND_W-1:0]  prod_w;

  // sync threshold: (random * sync_gain) >> 16, registered straight off the multiplier
  assign prod_w = (2*RAND_W)'(random_value_i) * (2*RAND_W)'(sync_gain_q);

  always_ff @(posedge clk_i) begin
    if (accept_w && !func_i) begin
      slot_q    <= slot_count_i;
      txs_q     <= tx_slot_i;
      nop_q     <= net_op_pending_i;
      hop_q     <= hop_pending_i;
      route_q   <= has_gateway_route_i;
      retries_q <= retries_i;
      thr_q     <= prod_w[2*RAND_W-1:RAND_W];
      // clamp the neighbour count to the table depth
      cnt_q     <= (32'(neighbour_count_i) > NEIGHBOUR_ENTRIES) ?
                   KCNT_W'(NEIGHBOUR_ENTRIES) : KCNT_W'(neighbour_count_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared remainder unit: one restoring step per cycle, four operations per tick
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] div_raw_w, div_w;
  logic [OFFS_W:0]  sh_w;
  logic [OFFS_W-1:0] rem_q, rem_nxt_w;
  logic             gps_z_q, flash_z_q, rx_z_q;

  always_comb begin
    unique case (op_q)
      OP_GPS:    div_raw_w = gps_wake_q;
      OP_FLASH:  div_raw_w = flash_save_q;
      OP_WINDOW: div_raw_w = window_len_q;
      OP_RXP:    div_raw_w = global_rx_q;
      default:   div_raw_w = global_rx_q;
    endcase
    // a zero period behaves as one
    div_w     = (div_raw_w == '0) ? CFG_W'(1) : div_raw_w;
    sh_w      = {rem_q, slot_q[bit_q]};
    rem_nxt_w = (sh_w >= {1'b0, div_w}) ? OFFS_W'(sh_w - {1'b0, div_w}) : sh_w[OFFS_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (accept_w && !func_i) begin
      op_q  <= OP_GPS;
      bit_q <= BIT_W'(SLOT_BITS - 1);
      rem_q <= '0;
    end else if (state_q == ST_MOD) begin
      if (bit_q == '0) begin
        // operation done: store the remainder and move on
        unique case (op_q)
          OP_GPS:    gps_z_q   <= (rem_nxt_w == '0);
          OP_FLASH:  flash_z_q <= (rem_nxt_w == '0);
          OP_WINDOW: offset_q  <= rem_nxt_w;
          OP_RXP:    rx_z_q    <= (rem_nxt_w == '0);
          default: ;
        endcase
        op_q  <= tss_op_e'(op_q + 2'd1);
        bit_q <= BIT_W'(SLOT_BITS - 1);
        rem_q <= '0;
      end else begin
        bit_q <= bit_q - 1'b1;
        rem_q <= rem_nxt_w;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Global slot decision
  // ---------------------------------------------------------------------------
  logic             upload_done_q;
  logic [OFFS_W-1:0] last_sync_q;
  logic [CMP_W-1:0] slot_ext_w, last_ext_w, thr_ext_w;
  logic             sync_lt_w, sync_gap_w;
  tss_mac_e         st_c;
  logic             run_c, cnop_c, cret_c, rreq_c, sync_hit_c, sync_clr_c, coll_c;

  assign slot_ext_w = CMP_W'(slot_q);
  assign last_ext_w = CMP_W'(last_sync_q);
  assign thr_ext_w  = CMP_W'(thr_q);
  assign sync_lt_w  = (slot_ext_w < last_ext_w);
  assign sync_gap_w = (CMP_W'(slot_ext_w - last_ext_w) > thr_ext_w);

  always_comb begin
    st_c       = MAC_DOZE;
    run_c      = 1'b0;
    cnop_c     = 1'b0;
    cret_c     = 1'b0;
    rreq_c     = 1'b0;
    sync_hit_c = 1'b0;
    sync_clr_c = 1'b0;
    if (rx_z_q) begin
      run_c = 1'b1;
      priority if (nop_q) begin
        st_c   = MAC_NETOP;
        cnop_c = 1'b1;
      end else if (hop_q) begin
        st_c = MAC_HOP;
        if (32'(retries_q) > RETRY_LIMIT) begin
          cret_c = 1'b1;
          st_c   = MAC_RECV;
        end
      end else if (retries_q != '0) begin
        // a root with retries pending keeps sleeping but still runs the MAC
        if (!is_root_q) begin
          st_c = MAC_RTS;
          if (32'(retries_q) > RETRY_LIMIT) begin
            cret_c = 1'b1;
            st_c   = MAC_RECV;
          end
        end
      end else if (sync_lt_w) begin
        // slot count went backwards: restart the sync reference
        sync_clr_c = 1'b1;
        st_c       = MAC_RECV;
      end else if (sync_gap_w) begin
        sync_hit_c = 1'b1;
        if (!route_q && !is_root_q) begin
          st_c   = MAC_NETOP;
          rreq_c = 1'b1;
        end else begin
          st_c = MAC_SYNC;
        end
      end else begin
        st_c = MAC_RECV;
      end
    end
    coll_c = (txs_q >= SLOT_BITS'(COLLECT_LEAD)) &&
             (slot_q == SLOT_BITS'(txs_q - SLOT_BITS'(COLLECT_LEAD)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upload_done_q <= 1'b0;
      last_sync_q   <= '0;
    end else if (state_q == ST_CALC) begin
      if (in_upload_w) begin
        upload_done_q <= upload_done_q | is_root_q;
      end else begin
        upload_done_q <= 1'b0;
        if (sync_clr_c) begin
          last_sync_q <= '0;
        end else if (sync_hit_c) begin
          last_sync_q <= OFFS_W'(slot_q);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Neighbour table and walk
  // ---------------------------------------------------------------------------
  logic [OFFS_W-1:0] nbr_mem [NEIGHBOUR_ENTRIES];
  logic [31:0]       widx_w;

  assign widx_w = 32'(entry_index_i);

  always_ff @(posedge clk_i) begin
    if (accept_w && func_i && (widx_w < NEIGHBOUR_ENTRIES)) begin
      nbr_mem[widx_w[IDX_W-1:0]] <= OFFS_W'(entry_slot_i);
    end
    if (state_q == ST_RD) begin
      rd_q <= nbr_mem[k_q[IDX_W-1:0]];
    end
  end

  // decision held across the walk
  tss_mac_e st_q;
  logic     run_q, up_q, upl_q, cnop_q, cret_q, rreq_q, coll_q, heard_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      k_q     <= '0;
      heard_q <= 1'b0;
      upl_q   <= in_upload_w;
      if (in_upload_w) begin
        st_q   <= MAC_DOZE;
        run_q  <= 1'b0;
        up_q   <= is_root_q && !upload_done_q;
        cnop_q <= 1'b0;
        cret_q <= 1'b0;
        rreq_q <= 1'b0;
        coll_q <= 1'b0;
      end else begin
        st_q   <= st_c;
        run_q  <= run_c;
        up_q   <= 1'b0;
        cnop_q <= cnop_c;
        cret_q <= cret_c;
        rreq_q <= rreq_c;
        coll_q <= coll_c;
      end
    end else if (state_q == ST_CMP) begin
      if (match_w) begin
        // a neighbour transmits now: listen
        heard_q <= 1'b1;
        st_q    <= MAC_RECV;
        run_q   <= 1'b1;
      end else begin
        k_q <= KCNT_W'(k_q + 1'b1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result registers
  // ---------------------------------------------------------------------------
  logic     done_q;
  tss_mac_e mac_q;
  logic     run_out_q, up_out_q, gps_out_q, flash_out_q, coll_out_q;
  logic     cnop_out_q, cret_out_q, rreq_out_q, heard_out_q;
  logic     own_tx_w;

  // own transmit slot (not on a root) wins the MAC state over every other choice outside the upload period
  assign own_tx_w = !upl_q && (slot_q == txs_q) && !is_root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (accept_w && func_i) || (state_q == ST_FINISH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w && func_i) begin
      // table write: all fields zero
      mac_q       <= MAC_DOZE;
      run_out_q   <= 1'b0;
      up_out_q    <= 1'b0;
      gps_out_q   <= 1'b0;
      flash_out_q <= 1'b0;
      coll_out_q  <= 1'b0;
      cnop_out_q  <= 1'b0;
      cret_out_q  <= 1'b0;
      rreq_out_q  <= 1'b0;
      heard_out_q <= 1'b0;
    end else if (state_q == ST_FINISH) begin
      mac_q       <= own_tx_w ? MAC_RTS : st_q;
      run_out_q   <= own_tx_w | run_q;
      up_out_q    <= up_q;
      gps_out_q   <= gps_z_q;
      flash_out_q <= flash_z_q;
      coll_out_q  <= coll_q;
      cnop_out_q  <= cnop_q;
      cret_out_q  <= cret_q;
      rreq_out_q  <= rreq_q;
      heard_out_q <= heard_q;
    end
  end

  assign done_o            = done_q;
  assign mac_state_o       = mac_q;
  assign run_mac_o         = run_out_q;
  assign start_upload_o    = up_out_q;
  assign gps_wake_o        = gps_out_q;
  assign save_flash_o      = flash_out_q;
  assign collect_data_o    = coll_out_q;
  assign clear_net_op_o    = cnop_out_q;
  assign clear_retries_o   = cret_out_q;
  assign request_route_o   = rreq_out_q;
  assign neighbour_heard_o = heard_out_q;

`ifndef SYNTHESIS
  a_tick_is_multicycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !func_i) |=> (busy_o && !done_o))
    else $error("tick result came too early");

  a_write_is_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && func_i) |=> (done_o && !busy_o && !run_mac_o))
    else $error("table write result missing or not zero");

  a_upload_sleeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && start_upload_o) |-> (!run_mac_o && mac_state_o == MAC_DOZE))
    else $error("upload slot did not sleep");

  a_heard_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && neighbour_heard_o) |-> (run_mac_o && !start_upload_o))
    else $error("neighbour heard without running the MAC");
`endif

endmodule

`default_nettype wire
